// ===== hw/rtl/nphb_pkg.sv =====
// shared types, constants and step table for the nearest point finder
package nphb_pkg;

    localparam int MAX_POINTS_DEF = 20;

    localparam int TW = 34;
    localparam int XW = 36;
    localparam int AW = 34;
    localparam int MW = 34;
    localparam int PW = 2 * MW;
    localparam int STEP_W = 5;

    localparam int CORDIC_ITERS = 30;
    localparam int DIV_STEPS = 3;
    localparam int SQRT_STEPS = 32;

    localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
    // odd factor of the degree scale, 112500000 = 2^5 * 3515625
    localparam logic [21:0] DEG_DIV = 22'd3515625;
    localparam logic [32:0] RECIP27 = 33'((64'd1 << 54) / 64'd3515625);
    localparam logic [32:0] RECIP26 = 33'((64'd1 << 53) / 64'd3515625);
    localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic signed [MW-1:0] CIRC2_M = 34'sd80060348;
    localparam logic signed [MW-1:0] HUNDREDTHS = 34'sd36000;

    localparam logic [1:0] REG_OWN_LAT = 2'd0;
    localparam logic [1:0] REG_OWN_LON = 2'd1;
    localparam logic [1:0] REG_HEADING = 2'd2;
    localparam logic [1:0] REG_MAX_DIST = 2'd3;

    localparam logic [STEP_W-1:0] ST_CV_LAT1 = 5'd0;
    localparam logic [STEP_W-1:0] ST_SC_LAT1 = 5'd1;
    localparam logic [STEP_W-1:0] ST_CV_LAT2 = 5'd2;
    localparam logic [STEP_W-1:0] ST_SC_LAT2 = 5'd3;
    localparam logic [STEP_W-1:0] ST_CV_DLAT = 5'd4;
    localparam logic [STEP_W-1:0] ST_SC_DLAT = 5'd5;
    localparam logic [STEP_W-1:0] ST_CV_DLONH = 5'd6;
    localparam logic [STEP_W-1:0] ST_SC_DLONH = 5'd7;
    localparam logic [STEP_W-1:0] ST_CV_DLON = 5'd8;
    localparam logic [STEP_W-1:0] ST_SC_DLON = 5'd9;
    localparam logic [STEP_W-1:0] ST_MU_CC = 5'd10;
    localparam logic [STEP_W-1:0] ST_MU_SS = 5'd11;
    localparam logic [STEP_W-1:0] ST_MU_P = 5'd12;
    localparam logic [STEP_W-1:0] ST_MU_A = 5'd13;
    localparam logic [STEP_W-1:0] ST_SQ_A = 5'd14;
    localparam logic [STEP_W-1:0] ST_SQ_B = 5'd15;
    localparam logic [STEP_W-1:0] ST_AT_C = 5'd16;
    localparam logic [STEP_W-1:0] ST_MU_M = 5'd17;
    localparam logic [STEP_W-1:0] ST_MU_BY = 5'd18;
    localparam logic [STEP_W-1:0] ST_MU_T1 = 5'd19;
    localparam logic [STEP_W-1:0] ST_MU_T2 = 5'd20;
    localparam logic [STEP_W-1:0] ST_MU_BX = 5'd21;
    localparam logic [STEP_W-1:0] ST_AT_B = 5'd22;
    localparam logic [STEP_W-1:0] ST_MU_BH = 5'd23;
    localparam logic [STEP_W-1:0] ST_UPD = 5'd24;

    typedef enum logic [2:0] {
        OP_CONV27,
        OP_CONV26,
        OP_SINCOS,
        OP_ATAN,
        OP_SQRT,
        OP_MUL,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        logic signed [30:0] point_latitude;
        logic signed [31:0] point_longitude;
        logic               has_point;
        logic               last;
    } in_t;

    typedef struct packed {
        logic [4:0]         point_count;
        logic signed [15:0] nearest_distance_m;
        logic signed [15:0] nearest_angle;
        logic               found;
    } out_t;

    typedef struct packed {
        logic signed [30:0] own_latitude;
        logic signed [31:0] own_longitude;
        logic [15:0]        own_heading;
        logic [14:0]        max_distance_m;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              take;
        logic              go;
        op_t               op;
        logic [STEP_W-1:0] step;
        logic              emit;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic full;
    } dp_status_t;

    function automatic op_t step_op(input logic [STEP_W-1:0] s);
        op_t r;
        begin
            case (s)
                ST_CV_LAT1, ST_CV_LAT2, ST_CV_DLON: r = OP_CONV27;
                ST_CV_DLAT, ST_CV_DLONH: r = OP_CONV26;
                ST_SC_LAT1, ST_SC_LAT2, ST_SC_DLAT, ST_SC_DLONH, ST_SC_DLON: r = OP_SINCOS;
                ST_SQ_A, ST_SQ_B: r = OP_SQRT;
                ST_AT_C, ST_AT_B: r = OP_ATAN;
                ST_MU_CC, ST_MU_SS, ST_MU_P, ST_MU_A, ST_MU_M, ST_MU_BY, ST_MU_T1,
                ST_MU_T2, ST_MU_BX, ST_MU_BH: r = OP_MUL;
                default: r = OP_UPDATE;
            endcase
            step_op = r;
        end
    endfunction

    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0: r = 30'd536870912;
                5'd1: r = 30'd316933406;
                5'd2: r = 30'd167458907;
                5'd3: r = 30'd85004756;
                5'd4: r = 30'd42667331;
                5'd5: r = 30'd21354465;
                5'd6: r = 30'd10679838;
                5'd7: r = 30'd5340245;
                5'd8: r = 30'd2670163;
                5'd9: r = 30'd1335087;
                5'd10: r = 30'd667544;
                5'd11: r = 30'd333772;
                5'd12: r = 30'd166886;
                5'd13: r = 30'd83443;
                5'd14: r = 30'd41722;
                5'd15: r = 30'd20861;
                5'd16: r = 30'd10430;
                5'd17: r = 30'd5215;
                5'd18: r = 30'd2608;
                5'd19: r = 30'd1304;
                5'd20: r = 30'd652;
                5'd21: r = 30'd326;
                5'd22: r = 30'd163;
                5'd23: r = 30'd81;
                5'd24: r = 30'd41;
                5'd25: r = 30'd20;
                5'd26: r = 30'd10;
                5'd27: r = 30'd5;
                5'd28: r = 30'd3;
                5'd29: r = 30'd1;
                default: r = 30'd0;
            endcase
            atan_lut = r;
        end
    endfunction

endpackage

// ===== hw/rtl/nphb_regs.sv =====
// apb configuration registers
module nphb_regs
    import nphb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic [1:0] idx;
    logic wr;

    assign idx = paddr[3:2];
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_latitude <= '0;
            cfg_reg.own_longitude <= '0;
            cfg_reg.own_heading <= '0;
            cfg_reg.max_distance_m <= 15'd5000;
        end
        else if (wr)
        begin
            case (idx)
                REG_OWN_LAT: cfg_reg.own_latitude <= pwdata[30:0];
                REG_OWN_LON: cfg_reg.own_longitude <= pwdata;
                REG_HEADING: cfg_reg.own_heading <= pwdata[15:0];
                REG_MAX_DIST: cfg_reg.max_distance_m <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_OWN_LAT: prdata = {cfg_reg.own_latitude[30], cfg_reg.own_latitude};
            REG_OWN_LON: prdata = cfg_reg.own_longitude;
            REG_HEADING: prdata = {16'd0, cfg_reg.own_heading};
            REG_MAX_DIST: prdata = {17'd0, cfg_reg.max_distance_m};
            default: prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/nphb_ctrl.sv =====
// controller state machine stepping through the per point program
module nphb_ctrl
    import nphb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       has_point,
    input  logic       last,
    input  dp_status_t status,
    output logic       busy,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] pc_reg, pc_next;
    logic last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            last_reg <= last_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        last_next = last_reg;
        cmd.load = 1'b0;
        cmd.take = 1'b0;
        cmd.go = 1'b0;
        cmd.op = step_op(pc_reg);
        cmd.step = pc_reg;
        cmd.emit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    last_next = last;
                    if (has_point && !status.full)
                    begin
                        cmd.take = 1'b1;
                        pc_next = ST_CV_LAT1;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.go = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.done)
                begin
                    if (pc_reg == ST_UPD)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.emit = last_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/nphb_cordic.sv =====
// iterative cordic, rotation mode for sine and cosine, vectoring mode for atan2
module nphb_cordic
    import nphb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 vector,
    input  logic [31:0]          angle,
    input  logic signed [XW-1:0] xin,
    input  logic signed [XW-1:0] yin,
    output logic signed [XW-1:0] xo,
    output logic signed [XW-1:0] yo,
    output logic [31:0]          zo,
    output logic                 done
);

    localparam logic signed [AW-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [AW-1:0] HALF = 34'sd2147483648;

    function automatic logic signed [XW-1:0] tshr(input logic signed [XW-1:0] v,
                                                 input logic [4:0] s);
        logic signed [XW-1:0] m;
        begin
            m = -v;
            tshr = v[XW-1] ? -(m >>> s) : (v >>> s);
        end
    endfunction

    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [AW-1:0] z_reg;
    logic neg_reg, zero_reg, vec_reg;
    logic run_reg, done_reg;
    logic [4:0] it_reg;

    logic signed [XW-1:0] tx, ty;
    logic signed [AW-1:0] at, zs;
    logic rpos;

    assign tx = tshr(x_reg, it_reg);
    assign ty = tshr(y_reg, it_reg);
    assign at = $signed({4'd0, atan_lut(it_reg)});
    assign rpos = vec_reg ? y_reg[XW-1] : !z_reg[AW-1];
    assign zs = $signed({{2{angle[31]}}, angle});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                it_reg <= '0;
            end
            else if (run_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == 5'(CORDIC_ITERS - 1))
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vec_reg <= vector;
            if (!vector)
            begin
                x_reg <= $signed({6'd0, CORDIC_GAIN});
                y_reg <= '0;
                zero_reg <= 1'b0;
                if (zs > QUARTER)
                begin
                    z_reg <= zs - HALF;
                    neg_reg <= 1'b1;
                end
                else if (zs < -QUARTER)
                begin
                    z_reg <= zs + HALF;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    z_reg <= zs;
                    neg_reg <= 1'b0;
                end
            end
            else
            begin
                neg_reg <= 1'b0;
                zero_reg <= (xin == '0) && (yin == '0);
                if (xin[XW-1])
                begin
                    x_reg <= -xin;
                    y_reg <= -yin;
                    z_reg <= HALF;
                end
                else
                begin
                    x_reg <= xin;
                    y_reg <= yin;
                    z_reg <= '0;
                end
            end
        end
        else if (run_reg)
        begin
            if (rpos)
            begin
                x_reg <= x_reg - ty;
                y_reg <= y_reg + tx;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ty;
                y_reg <= y_reg - tx;
                z_reg <= z_reg + at;
            end
        end
    end

    assign xo = neg_reg ? -x_reg : x_reg;
    assign yo = neg_reg ? -y_reg : y_reg;
    assign zo = zero_reg ? 32'd0 : z_reg[31:0];
    assign done = done_reg;

endmodule

// ===== hw/rtl/nphb_dp.sv =====
// datapath: degree converter, cordic, square root, multiplier and batch state
module nphb_dp
    import nphb_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  in_t        item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_t       result,
    output logic       result_valid
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic signed [30:0] lat2_reg;
    logic signed [31:0] lon2_reg;
    logic [31:0] u_reg;
    logic signed [TW-1:0] sl1_reg, cl1_reg, sl2_reg, cl2_reg;
    logic signed [TW-1:0] sh1_reg, sh2_reg, sd_reg, cd_reg;
    logic signed [TW-1:0] t1_reg, t2_reg, by_reg, bx_reg;
    logic signed [63:0] p_reg;
    logic [60:0] a_reg;
    logic [30:0] sa_reg, sb_reg;
    logic [31:0] ang_reg;
    logic [26:0] meters_reg;
    logic [15:0] bh_reg;

    logic [31:0] dmag_reg;
    logic [65:0] cprod_reg;
    logic [32:0] qest_reg;
    logic dneg_reg;

    logic [63:0] sv_reg, sr_reg, sbit_reg;
    logic signed [PW-1:0] prod_reg;

    logic run_reg, done_reg;
    op_t op_reg;
    logic [STEP_W-1:0] step_reg;
    logic [5:0] iter_reg;

    logic [CNT_W-1:0] count_reg;
    logic [26:0] best_dist_reg;
    logic signed [15:0] best_ang_reg;
    logic best_valid_reg;
    out_t res_reg;
    logic res_valid_reg;

    // degree to binary angle conversion by reciprocal multiplication
    logic signed [32:0] lat1_x, lat2_x, lon1_x, lon2_x, dlat, dlon, dsrc, dmag;
    logic [32:0] crecip, cm_a, cm_b, cq;
    logic [55:0] cnum, crem;

    assign lat1_x = $signed({{2{cfg.own_latitude[30]}}, cfg.own_latitude});
    assign lat2_x = $signed({{2{lat2_reg[30]}}, lat2_reg});
    assign lon1_x = $signed({cfg.own_longitude[31], cfg.own_longitude});
    assign lon2_x = $signed({lon2_reg[31], lon2_reg});
    assign dlat = lat2_x - lat1_x;
    assign dlon = lon2_x - lon1_x;

    always_comb
    begin
        case (cmd.step)
            ST_CV_LAT1: dsrc = lat1_x;
            ST_CV_LAT2: dsrc = lat2_x;
            ST_CV_DLAT: dsrc = dlat;
            default: dsrc = dlon;
        endcase
    end

    assign dmag = dsrc[32] ? -dsrc : dsrc;
    assign crecip = (op_reg == OP_CONV27) ? RECIP27 : RECIP26;
    assign cm_a = (iter_reg == 6'd0) ? {1'b0, dmag_reg} : cprod_reg[64:32];
    assign cm_b = (iter_reg == 6'd0) ? crecip : {11'd0, DEG_DIV};
    assign cnum = (op_reg == OP_CONV27) ? {2'b0, dmag_reg, 22'd0} : {3'b0, dmag_reg, 21'd0};
    assign crem = cnum - cprod_reg[55:0];
    assign cq = (crem >= {34'd0, DEG_DIV}) ? qest_reg + 33'd1 : qest_reg;

    // square root digit step
    logic [63:0] ssum, sv_new, sr_new;
    logic sge;

    assign ssum = sr_reg + sbit_reg;
    assign sge = (sv_reg >= ssum);
    assign sv_new = sge ? sv_reg - ssum : sv_reg;
    assign sr_new = sge ? (sr_reg >> 1) + sbit_reg : (sr_reg >> 1);

    // multiplier operands and post processing
    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] pneg, qfull, asum;
    logic signed [TW-1:0] qv;
    logic [60:0] aclamp;

    always_comb
    begin
        case (cmd.step)
            ST_MU_CC: begin ma = cl1_reg; mb = cl2_reg; end
            ST_MU_SS: begin ma = sh2_reg; mb = sh2_reg; end
            ST_MU_P: begin ma = t1_reg; mb = t2_reg; end
            ST_MU_A: begin ma = sh1_reg; mb = sh1_reg; end
            ST_MU_M: begin ma = $signed({2'b0, ang_reg}); mb = CIRC2_M; end
            ST_MU_BY: begin ma = sd_reg; mb = cl2_reg; end
            ST_MU_T1: begin ma = cl1_reg; mb = sl2_reg; end
            ST_MU_T2: begin ma = sl1_reg; mb = cl2_reg; end
            ST_MU_BX: begin ma = t2_reg; mb = cd_reg; end
            ST_MU_BH: begin ma = $signed({2'b0, ang_reg}); mb = HUNDREDTHS; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign pneg = -prod_reg;
    assign qfull = prod_reg[PW-1] ? -(pneg >>> 30) : (prod_reg >>> 30);
    assign qv = qfull[TW-1:0];
    assign asum = prod_reg + $signed({{(PW-64){p_reg[63]}}, p_reg});

    always_comb
    begin
        if (asum[PW-1])
        begin
            aclamp = '0;
        end
        else if (asum[PW-2:0] > (PW-1)'(ONE_Q60))
        begin
            aclamp = ONE_Q60;
        end
        else
        begin
            aclamp = asum[60:0];
        end
    end

    // cordic hookup
    logic c_start, c_vec, c_done;
    logic signed [XW-1:0] c_xin, c_yin, c_xo, c_yo;
    logic [31:0] c_zo;

    assign c_start = cmd.go && ((cmd.op == OP_SINCOS) || (cmd.op == OP_ATAN));
    assign c_vec = (cmd.op == OP_ATAN);

    always_comb
    begin
        case (cmd.step)
            ST_AT_C:
            begin
                c_xin = $signed({5'd0, sb_reg});
                c_yin = $signed({5'd0, sa_reg});
            end
            default:
            begin
                c_xin = $signed({{(XW-TW){bx_reg[TW-1]}}, bx_reg});
                c_yin = $signed({{(XW-TW){by_reg[TW-1]}}, by_reg});
            end
        endcase
    end

    nphb_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (c_start),
        .vector (c_vec),
        .angle  (u_reg),
        .xin    (c_xin),
        .yin    (c_yin),
        .xo     (c_xo),
        .yo     (c_yo),
        .zo     (c_zo),
        .done   (c_done)
    );

    // best point update
    logic [15:0] lim;
    logic upd_ok;
    logic signed [17:0] rdelta, rmod, rnorm;

    assign lim = {1'b0, cfg.max_distance_m} + 16'd1000;
    assign upd_ok = (meters_reg < 27'(lim)) &&
                    (!best_valid_reg || (meters_reg < best_dist_reg));
    assign rdelta = $signed({2'b00, bh_reg}) - $signed({2'b00, cfg.own_heading});
    assign rmod = (rdelta <= -18'sd36000) ? rdelta + 18'sd36000 : rdelta;
    assign rnorm = (rmod > 18'sd18000) ? rmod - 18'sd36000 :
                   ((rmod <= -18'sd18000) ? rmod + 18'sd36000 : rmod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg <= OP_UPDATE;
            step_reg <= '0;
            iter_reg <= '0;
            count_reg <= '0;
            best_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            res_valid_reg <= cmd.emit;
            if (cmd.take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.go)
            begin
                op_reg <= cmd.op;
                step_reg <= cmd.step;
                iter_reg <= '0;
                if (cmd.op == OP_UPDATE)
                begin
                    done_reg <= 1'b1;
                    if (upd_ok)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                case (op_reg)
                    OP_CONV27, OP_CONV26:
                    begin
                        if (iter_reg == 6'(DIV_STEPS - 1))
                        begin
                            run_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    OP_SQRT:
                    begin
                        if (iter_reg == 6'(SQRT_STEPS - 1))
                        begin
                            run_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    OP_SINCOS, OP_ATAN:
                    begin
                        if (c_done)
                        begin
                            run_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        run_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
            if (cmd.emit)
            begin
                count_reg <= '0;
                best_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lat2_reg <= item.point_latitude;
            lon2_reg <= item.point_longitude;
        end
        if (cmd.go)
        begin
            case (cmd.op)
                OP_CONV27, OP_CONV26:
                begin
                    dmag_reg <= dmag[31:0];
                    dneg_reg <= dsrc[32];
                end
                OP_SQRT:
                begin
                    sv_reg <= (cmd.step == ST_SQ_A) ? 64'(a_reg) : 64'(ONE_Q60 - a_reg);
                    sr_reg <= '0;
                    sbit_reg <= SQRT_BIT0;
                end
                OP_MUL:
                begin
                    prod_reg <= ma * mb;
                end
                OP_UPDATE:
                begin
                    if (upd_ok)
                    begin
                        best_dist_reg <= meters_reg;
                        best_ang_reg <= rnorm[15:0];
                    end
                end
                default: ;
            endcase
        end
        else if (run_reg)
        begin
            case (op_reg)
                OP_CONV27, OP_CONV26:
                begin
                    cprod_reg <= {33'd0, cm_a} * {33'd0, cm_b};
                    if (iter_reg == 6'd1)
                    begin
                        qest_reg <= cprod_reg[64:32];
                    end
                    if (iter_reg == 6'(DIV_STEPS - 1))
                    begin
                        u_reg <= dneg_reg ? -cq[31:0] : cq[31:0];
                    end
                end
                OP_SQRT:
                begin
                    sv_reg <= sv_new;
                    sr_reg <= sr_new;
                    sbit_reg <= sbit_reg >> 2;
                    if (iter_reg == 6'(SQRT_STEPS - 1))
                    begin
                        if (step_reg == ST_SQ_A)
                        begin
                            sa_reg <= sr_new[30:0];
                        end
                        else
                        begin
                            sb_reg <= sr_new[30:0];
                        end
                    end
                end
                OP_MUL:
                begin
                    case (step_reg)
                        ST_MU_CC: t1_reg <= qv;
                        ST_MU_SS: t2_reg <= qv;
                        ST_MU_P: p_reg <= prod_reg[63:0];
                        ST_MU_A: a_reg <= aclamp;
                        ST_MU_M: meters_reg <= prod_reg[58:32];
                        ST_MU_BY: by_reg <= qv;
                        ST_MU_T1: t1_reg <= qv;
                        ST_MU_T2: t2_reg <= qv;
                        ST_MU_BX: bx_reg <= t1_reg - qv;
                        ST_MU_BH: bh_reg <= prod_reg[47:32];
                        default: ;
                    endcase
                end
                OP_SINCOS:
                begin
                    if (c_done)
                    begin
                        case (step_reg)
                            ST_SC_LAT1:
                            begin
                                sl1_reg <= c_yo[TW-1:0];
                                cl1_reg <= c_xo[TW-1:0];
                            end
                            ST_SC_LAT2:
                            begin
                                sl2_reg <= c_yo[TW-1:0];
                                cl2_reg <= c_xo[TW-1:0];
                            end
                            ST_SC_DLAT: sh1_reg <= c_yo[TW-1:0];
                            ST_SC_DLONH: sh2_reg <= c_yo[TW-1:0];
                            ST_SC_DLON:
                            begin
                                sd_reg <= c_yo[TW-1:0];
                                cd_reg <= c_xo[TW-1:0];
                            end
                            default: ;
                        endcase
                    end
                end
                OP_ATAN:
                begin
                    if (c_done)
                    begin
                        ang_reg <= c_zo;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.emit)
        begin
            res_reg.point_count <= 5'(count_reg);
            res_reg.found <= best_valid_reg;
            if (best_valid_reg)
            begin
                res_reg.nearest_distance_m <= (best_dist_reg > 27'd32767) ? 16'sd32767
                                              : $signed(best_dist_reg[15:0]);
                res_reg.nearest_angle <= best_ang_reg;
            end
            else
            begin
                res_reg.nearest_distance_m <= -16'sd1;
                res_reg.nearest_angle <= '0;
            end
        end
    end

    assign status.done = done_reg;
    assign status.full = (count_reg >= CNT_W'(MAX_POINTS));
    assign result = res_reg;
    assign result_valid = res_valid_reg;

endmodule

// ===== hw/rtl/nearest_point_haversine_bearing.sv =====
// top level of the nearest point finder: distance and relative bearing per batch
// a point transaction runs five 3-step degree conversions, the shared 30-iteration cordic
// seven times and two square roots, with busy high until the transaction is through
// an empty or capped transaction skips the program; one item is worked on at a time
// the result strobe rises the cycle after the last transaction finishes and lasts one cycle
// reset clears the batch and loads default configuration, no clearing pass
module nearest_point_haversine_bearing
    import nphb_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  in_t         item,
    output out_t        result,
    output logic        result_valid
);

    cfg_t cfg;
    dp_cmd_t cmd;
    dp_status_t status;

    nphb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nphb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .has_point (item.has_point),
        .last      (item.last),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    nphb_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
